FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL of the token uncertainty scorer.
// Each helper checks an implication on the rising clock edge and is
// switched off while the asynchronous reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/tus_pkg.sv
package tus_pkg;

	// Fixed-point constants, Q32.32 unless noted.
	localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
	localparam logic [63:0] TWO_Q32   = 64'h0000_0002_0000_0000;
	localparam logic [63:0] LN2_Q32   = 64'd2977044472;
	// exp(-x) is zero once x reaches forty times ln 2.
	localparam logic [63:0] EXP_LIMIT = 64'd119081778880;
	localparam logic [3:0]  EXP_TERMS = 4'd14;
	localparam logic [3:0]  LN_TERMS  = 4'd11;
	localparam logic [5:0]  LN_E_MAX  = 6'd40;
	localparam logic [63:0] HN_CAP    = 64'd65536;
	localparam logic [63:0] SCORE_MAX = 64'd65535;

	// Sequencer states.
	typedef enum logic [5:0] {
		S_IDLE,
		S_ROW_MAX,
		S_ROW_D,
		S_ROW_ACC,
		S_ROW_ACC_W,
		S_ROW_Q,
		S_ROW_F,
		S_ROW_A,
		S_ROW_L,
		S_ROW_LK,
		S_ROW_HN,
		S_TOK_START,
		S_TOK_S,
		S_FIN_ENT,
		S_FIN_ENT_Q,
		S_FIN_PERP,
		S_FIN_PERP_X,
		S_FIN_OUT,
		S_EXP_START,
		S_EXP_N,
		S_EXP_MUL,
		S_EXP_DIV,
		S_EXP_ACC,
		S_EXP_FIN,
		S_LN_START,
		S_LN_NORM,
		S_LN_S2,
		S_LN_SQM,
		S_LN_SQ,
		S_LN_MUL,
		S_LN_DIV,
		S_LN_ACC,
		S_LN_FIN,
		S_DIV_WAIT
	} state_t;

	// Divider request and response.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic [63:0] rem;
	} div_rsp_t;

	// Multiplier operands.
	typedef struct packed {
		logic [32:0] a;
		logic [32:0] b;
	} mul_req_t;

endpackage

FILE: rtl/core/tus_in_if.sv
interface tus_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] selected_logprob;
	logic        [3:0]  row_count;
	logic signed [15:0] cand_0;
	logic signed [15:0] cand_1;
	logic signed [15:0] cand_2;
	logic signed [15:0] cand_3;
	logic signed [15:0] cand_4;
	logic signed [15:0] cand_5;
	logic signed [15:0] cand_6;
	logic signed [15:0] cand_7;
	logic               last_token;

	modport source (
		output valid, selected_logprob, row_count,
		output cand_0, cand_1, cand_2, cand_3, cand_4, cand_5, cand_6, cand_7,
		output last_token,
		input  ready
	);

	modport sink (
		input  valid, selected_logprob, row_count,
		input  cand_0, cand_1, cand_2, cand_3, cand_4, cand_5, cand_6, cand_7,
		input  last_token,
		output ready
	);
endinterface

FILE: rtl/core/tus_out_if.sv
interface tus_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] score_max_token;
	logic [15:0] score_entropy;
	logic [15:0] score_perplexity;
	logic [15:0] tokens_seen;

	modport source (
		output valid, score_max_token, score_entropy, score_perplexity, tokens_seen,
		input  ready
	);

	modport sink (
		input  valid, score_max_token, score_entropy, score_perplexity, tokens_seen,
		output ready
	);
endinterface

FILE: rtl/core/token_uncertainty_scores_top.sv
// Token uncertainty scorer.
// The tokens channel carries one generated token per request: its selected
// log-probability, a row of up to eight candidate log-probabilities with a
// count, and a last-token flag. The scores channel returns one request per
// sequence, on its last token: max token score, mean normalized entropy,
// perplexity score and the token count.
// Tokens are processed one at a time; ready is high only between tokens.
// Every exp and log runs its series through one shared 64-step divider and
// one registered multiplier, so the divider sets the rate.
// The scores sit in an output register, so the next token is taken while a
// result waits. If a second result is ready before the first is taken, the
// sequencer holds until the scores channel drains.
// Reset clears all running sums, counts and the output valid.
`include "assert_macros.svh"

module token_uncertainty_scores_top
	import tus_pkg::*;
#(
	parameter int TOP_K_MAX  = 8,
	parameter int COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tus_in_if.sink    tokens,
	tus_out_if.source scores
);

	localparam int IDX_W = $clog2(TOP_K_MAX);
	localparam int KW    = $clog2(TOP_K_MAX + 1);
	localparam int TOT_W = COUNT_BITS + 16;
	localparam int ETOT_W = COUNT_BITS + 17;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;
	state_t ret_q, dret_q, div_ret;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	logic [65:0] mul_p;

	// Item registers.
	logic signed [15:0] lp_q;
	logic               last_q;
	logic [KW-1:0]      k_q;
	logic [IDX_W-1:0]   idx_q;
	logic signed [15:0] c_q [TOP_K_MAX];
	logic signed [15:0] m_q;
	logic [15:0]        d_q;

	// Row working registers.
	logic [63:0] z_q, w_q, qq_q, a_q, l_q;

	// Exp and log working registers.
	logic [63:0] x_q, r_q, t_q, pos_q, neg_q, er_q;
	logic [5:0]  n_q;
	logic [3:0]  j_q;
	logic [63:0] lz_q, sum_q, lr_q;
	logic [5:0]  le_q;
	logic [31:0] s2_q;
	logic [15:0] ent_q;

	// Sequence state.
	logic [15:0]              max_q;
	logic signed [TOT_W-1:0]  total_q;
	logic [COUNT_BITS-1:0]    tally_q;
	logic [ETOT_W-1:0]        etot_q;
	logic [COUNT_BITS-1:0]    rows_q;

	// Output register.
	logic        ov_q;
	logic [15:0] o_max_q, o_ent_q, o_perp_q, o_tok_q;

	logic signed [15:0] cand_in [8];
	logic [3:0]         k_in;
	logic               accept;
	logic               idx_last;
	logic signed [15:0] c_cur;
	logic signed [16:0] d_diff;
	logic [15:0]        d_cur;
	logic [16:0]        lp_mag;
	logic [63:0]        h_val;
	logic [63:0]        hn_num;
	logic [16:0]        hn_val;
	logic [TOT_W-1:0]   tot_mag;
	logic               perp_go;
	logic               x_big;
	logic               ln_norm;
	logic [63:0]        exp_diff;
	logic [63:0]        mul_hi;
	logic [15:0]        er_score;
	logic [15:0]        tok_sat;
	logic               out_free;
	logic               out_load;

	// Rounded 1 - e in Q0.16, clamped.
	function automatic logic [15:0] one_minus_q16(input logic [63:0] e);
		logic [63:0] v;
		if (e >= ONE_Q32) return 16'd0;
		v = ((ONE_Q32 - e) + 64'd32768) >> 16;
		return (v > SCORE_MAX) ? 16'hFFFF : v[15:0];
	endfunction

	tus_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tus_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.p_s1 (mul_p)
	);

	// Input unpacking and derived values.
	always_comb begin
		cand_in[0] = tokens.cand_0;
		cand_in[1] = tokens.cand_1;
		cand_in[2] = tokens.cand_2;
		cand_in[3] = tokens.cand_3;
		cand_in[4] = tokens.cand_4;
		cand_in[5] = tokens.cand_5;
		cand_in[6] = tokens.cand_6;
		cand_in[7] = tokens.cand_7;
		k_in = (tokens.row_count > 4'(TOP_K_MAX)) ? 4'(TOP_K_MAX) : tokens.row_count;
		accept   = tokens.valid && tokens.ready;
		idx_last = (KW'(idx_q) == k_q - KW'(1));
		c_cur    = c_q[idx_q];
		d_diff   = 17'(m_q) - 17'(c_cur);
		d_cur    = d_diff[15:0];
		lp_mag   = -{lp_q[15], lp_q};
		h_val    = (l_q > a_q) ? l_q - a_q : 64'd0;
		hn_num   = (h_val << 16) + (lr_q >> 1);
		hn_val   = (div_rsp.quot > HN_CAP) ? 17'h10000 : div_rsp.quot[16:0];
		tot_mag  = TOT_W'(-total_q);
		perp_go  = (tally_q != '0) && total_q[TOT_W-1];
		x_big    = x_q >= EXP_LIMIT;
		ln_norm  = (lz_q >= TWO_Q32) && (le_q < LN_E_MAX);
		exp_diff = (pos_q > neg_q) ? pos_q - neg_q : 64'd0;
		mul_hi   = 64'(mul_p >> 32);
		er_score = one_minus_q16(er_q);
		tok_sat  = (32'(tally_q) > 32'd65535) ? 16'hFFFF : 16'(tally_q);
		out_free = !ov_q || scores.ready;
		out_load = (state_q == S_FIN_OUT) && out_free;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = (k_in >= 4'd2) ? S_ROW_MAX : S_TOK_START;
			end
			S_ROW_MAX: begin
				if (idx_last) state_d = S_ROW_D;
			end
			S_ROW_D:      state_d = S_EXP_START;
			S_ROW_ACC:    state_d = S_ROW_ACC_W;
			S_ROW_ACC_W:  state_d = idx_last ? S_ROW_Q : S_ROW_D;
			S_ROW_Q:      state_d = S_DIV_WAIT;
			S_ROW_F:      state_d = S_DIV_WAIT;
			S_ROW_A:      state_d = S_LN_START;
			S_ROW_L:      state_d = S_LN_START;
			S_ROW_LK:     state_d = S_DIV_WAIT;
			S_ROW_HN:     state_d = S_TOK_START;
			S_TOK_START:  state_d = lp_q[15] ? S_EXP_START : S_TOK_S;
			S_TOK_S:      state_d = last_q ? S_FIN_ENT : S_IDLE;
			S_FIN_ENT:    state_d = (rows_q != '0) ? S_DIV_WAIT : S_FIN_PERP;
			S_FIN_ENT_Q:  state_d = S_FIN_PERP;
			S_FIN_PERP:   state_d = perp_go ? S_DIV_WAIT : S_FIN_OUT;
			S_FIN_PERP_X: state_d = S_EXP_START;
			S_FIN_OUT: begin
				if (out_free) state_d = S_IDLE;
			end
			S_EXP_START:  state_d = x_big ? ret_q : S_EXP_N;
			S_EXP_N:      state_d = (r_q >= LN2_Q32) ? S_EXP_N : S_EXP_MUL;
			S_EXP_MUL:    state_d = S_EXP_DIV;
			S_EXP_DIV:    state_d = S_DIV_WAIT;
			S_EXP_ACC:    state_d = (j_q == EXP_TERMS) ? S_EXP_FIN : S_EXP_MUL;
			S_EXP_FIN:    state_d = ret_q;
			S_LN_START:   state_d = (lz_q < ONE_Q32) ? ret_q : S_LN_NORM;
			S_LN_NORM:    state_d = ln_norm ? S_LN_NORM : S_DIV_WAIT;
			S_LN_S2:      state_d = S_LN_SQM;
			S_LN_SQM:     state_d = S_LN_SQ;
			S_LN_SQ:      state_d = S_LN_MUL;
			S_LN_MUL:     state_d = S_LN_DIV;
			S_LN_DIV:     state_d = S_DIV_WAIT;
			S_LN_ACC:     state_d = (j_q == LN_TERMS) ? S_LN_FIN : S_LN_MUL;
			S_LN_FIN:     state_d = ret_q;
			S_DIV_WAIT: begin
				if (div_rsp.done) state_d = dret_q;
			end
			default:      state_d = S_IDLE;
		endcase
	end

	// Divider and multiplier requests per state.
	always_comb begin
		div_req = '0;
		div_ret = S_IDLE;
		mul_req = '0;
		unique case (state_q)
			S_ROW_Q: begin
				div_req = '{start: 1'b1, dividend: w_q, divisor: z_q};
				div_ret = S_ROW_F;
			end
			S_ROW_F: begin
				div_req = '{start: 1'b1, dividend: div_rsp.rem << 22, divisor: z_q};
				div_ret = S_ROW_A;
			end
			S_ROW_LK: begin
				div_req = '{start: 1'b1, dividend: hn_num, divisor: lr_q};
				div_ret = S_ROW_HN;
			end
			S_FIN_ENT: begin
				if (rows_q != '0) begin
					div_req.start    = 1'b1;
					div_req.dividend = 64'(etot_q) + 64'(rows_q >> 1);
					div_req.divisor  = 64'(rows_q);
					div_ret = S_FIN_ENT_Q;
				end
			end
			S_FIN_PERP: begin
				if (perp_go) begin
					div_req.start    = 1'b1;
					div_req.dividend = 64'(tot_mag) << 22;
					div_req.divisor  = 64'(tally_q);
					div_ret = S_FIN_PERP_X;
				end
			end
			S_EXP_DIV: begin
				div_req = '{start: 1'b1, dividend: mul_hi, divisor: 64'(j_q)};
				div_ret = S_EXP_ACC;
			end
			S_LN_NORM: begin
				if (!ln_norm) begin
					div_req.start    = 1'b1;
					div_req.dividend = (lz_q - ONE_Q32) << 32;
					div_req.divisor  = lz_q + ONE_Q32;
					div_ret = S_LN_S2;
				end
			end
			S_LN_DIV: begin
				div_req = '{start: 1'b1, dividend: mul_hi, divisor: 64'({j_q, 1'b1})};
				div_ret = S_LN_ACC;
			end
			S_ROW_ACC: mul_req = '{a: er_q[32:0], b: {17'b0, d_q}};
			S_EXP_MUL: mul_req = '{a: t_q[32:0], b: r_q[32:0]};
			S_LN_SQM:  mul_req = '{a: t_q[32:0], b: t_q[32:0]};
			S_LN_MUL:  mul_req = '{a: t_q[32:0], b: {1'b0, s2_q}};
			default: ;
		endcase
	end

	assign tokens.ready = (state_q == S_IDLE);

	// Sequencer control and sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			dret_q  <= S_IDLE;
			max_q   <= '0;
			total_q <= '0;
			tally_q <= '0;
			etot_q  <= '0;
			rows_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (div_req.start) dret_q <= div_ret;
			if (out_load) ov_q <= 1'b1;
			else if (scores.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_ROW_D:      ret_q <= S_ROW_ACC;
				S_ROW_A:      ret_q <= S_ROW_L;
				S_ROW_L:      ret_q <= S_ROW_LK;
				S_TOK_START:  ret_q <= S_TOK_S;
				S_FIN_PERP_X: ret_q <= S_FIN_OUT;
				S_ROW_HN: begin
					if (rows_q < COUNT_MAX) begin
						etot_q <= etot_q + ETOT_W'(hn_val);
						rows_q <= rows_q + 1'b1;
					end
				end
				S_TOK_S: begin
					if (er_score > max_q) max_q <= er_score;
					if (tally_q < COUNT_MAX) begin
						total_q <= total_q + TOT_W'(lp_q);
						tally_q <= tally_q + 1'b1;
					end
				end
				S_FIN_OUT: begin
					if (out_free) begin
						max_q   <= '0;
						total_q <= '0;
						tally_q <= '0;
						etot_q  <= '0;
						rows_q  <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_max_q  <= max_q;
			o_ent_q  <= ent_q;
			o_perp_q <= er_score;
			o_tok_q  <= tok_sat;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					lp_q   <= tokens.selected_logprob;
					last_q <= tokens.last_token;
					k_q    <= KW'(k_in);
					for (int i = 0; i < TOP_K_MAX; i++) c_q[i] <= cand_in[i];
					m_q    <= cand_in[0];
					idx_q  <= IDX_W'(1);
				end
			end
			S_ROW_MAX: begin
				if (c_cur > m_q) m_q <= c_cur;
				if (idx_last) begin
					idx_q <= '0;
					z_q   <= '0;
					w_q   <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_ROW_D: begin
				d_q <= d_cur;
				x_q <= 64'(d_cur) << 22;
			end
			S_ROW_ACC: z_q <= z_q + er_q;
			S_ROW_ACC_W: begin
				w_q <= w_q + mul_p[63:0];
				if (!idx_last) idx_q <= idx_q + 1'b1;
			end
			S_ROW_F: qq_q <= div_rsp.quot;
			S_ROW_A: begin
				a_q  <= (qq_q << 22) + div_rsp.quot;
				lz_q <= z_q;
			end
			S_ROW_L: begin
				l_q  <= lr_q;
				lz_q <= 64'(k_q) << 32;
			end
			S_TOK_START: begin
				if (lp_q[15]) x_q <= 64'(lp_mag) << 22;
				else er_q <= ONE_Q32;
			end
			S_FIN_ENT: begin
				if (rows_q == '0) ent_q <= '0;
			end
			S_FIN_ENT_Q: begin
				ent_q <= (div_rsp.quot > SCORE_MAX) ? 16'hFFFF : div_rsp.quot[15:0];
			end
			S_FIN_PERP: begin
				if (!perp_go) er_q <= ONE_Q32;
			end
			S_FIN_PERP_X: x_q <= div_rsp.quot;
			// exp(-x): range reduction, then the alternating series.
			S_EXP_START: begin
				if (x_big) begin
					er_q <= '0;
				end else begin
					r_q <= x_q;
					n_q <= '0;
				end
			end
			// Take ln 2 off one step at a time; fewer than forty steps remain.
			S_EXP_N: begin
				if (r_q >= LN2_Q32) begin
					r_q <= r_q - LN2_Q32;
					n_q <= n_q + 6'd1;
				end else begin
					t_q   <= ONE_Q32;
					pos_q <= ONE_Q32;
					neg_q <= '0;
					j_q   <= 4'd1;
				end
			end
			S_EXP_ACC: begin
				t_q <= div_rsp.quot;
				if (j_q[0]) neg_q <= neg_q + div_rsp.quot;
				else pos_q <= pos_q + div_rsp.quot;
				j_q <= j_q + 4'd1;
			end
			S_EXP_FIN: er_q <= exp_diff >> n_q;
			// ln z: normalize to [1,2), then the atanh series.
			S_LN_START: begin
				if (lz_q < ONE_Q32) lr_q <= '0;
				le_q <= '0;
			end
			S_LN_NORM: begin
				if (ln_norm) begin
					lz_q <= lz_q >> 1;
					le_q <= le_q + 6'd1;
				end
			end
			S_LN_S2: begin
				t_q   <= div_rsp.quot;
				sum_q <= div_rsp.quot;
			end
			S_LN_SQ: begin
				s2_q <= mul_hi[31:0];
				j_q  <= 4'd1;
			end
			S_LN_DIV: t_q <= mul_hi;
			S_LN_ACC: begin
				sum_q <= sum_q + div_rsp.quot;
				j_q   <= j_q + 4'd1;
			end
			S_LN_FIN: lr_q <= 64'(le_q) * LN2_Q32 + (sum_q << 1);
			default: ;
		endcase
	end

	assign scores.valid            = ov_q;
	assign scores.score_max_token  = o_max_q;
	assign scores.score_entropy    = o_ent_q;
	assign scores.score_perplexity = o_perp_q;
	assign scores.tokens_seen      = o_tok_q;

	`ASSERT_NEXT(a_result_clears, clk, arst_n, out_load, scores.valid && tally_q == '0)
	`ASSERT_IMPL(a_rows_le_tally, clk, arst_n, state_q == S_IDLE, rows_q <= tally_q)
	`ASSERT_IMPL(a_max_needs_token, clk, arst_n, max_q != '0, tally_q != '0)
	`ASSERT_NEXT(a_div_waits, clk, arst_n, div_req.start, state_q == S_DIV_WAIT)

endmodule

FILE: rtl/core/tus_mul.sv
module tus_mul
	import tus_pkg::*;
(
	input  logic        clk,
	input  mul_req_t    req,
	output logic [65:0] p_s1
);

	// Registered 33 by 33 unsigned product, ready in the cycle after the request.
	always_ff @(posedge clk) begin
		p_s1 <= {33'b0, req.a} * {33'b0, req.b};
	end

endmodule

FILE: rtl/core/tus_div.sv
`include "assert_macros.svh"

module tus_div
	import tus_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] dvs_q;
	logic [64:0] rem_sh;
	logic        fits;
	logic [64:0] rem_sub;

	// One restoring step: shift in the next dividend bit and try the divisor.
	always_comb begin
		rem_sh  = {rem_q, quo_q[63]};
		fits    = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control: 64 steps per request, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient and remainder registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], fits};
			rem_q <= fits ? rem_sub[63:0] : rem_sh[63:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	`ASSERT_IMPL(a_no_start_busy, clk, arst_n, req.start, !busy_q)
	`ASSERT_NEXT(a_done_at_end, clk, arst_n, busy_q && !req.start && cnt_q == 6'd0, done_q)
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done_q, !busy_q)

endmodule
